// ===== src/cli_pkg.sv =====
// Shared types and constants of the cyclic line intersection unit.
// Used by the controller, the datapath, the divider and the top level; no dependencies.
package cli_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [2:0] PROD_DET0  = 3'd0;
    localparam logic [2:0] PROD_DET1  = 3'd1;
    localparam logic [2:0] PROD_DX0   = 3'd2;
    localparam logic [2:0] PROD_DX1   = 3'd3;
    localparam logic [2:0] PROD_DY0   = 3'd4;
    localparam logic [2:0] PROD_DY1   = 3'd5;
    localparam logic [2:0] PROD_COUNT = 3'd6;

    localparam logic DIV_SEL_X = 1'b0;
    localparam logic DIV_SEL_Y = 1'b1;

    localparam logic PAIR_PREV_CUR  = 1'b0;
    localparam logic PAIR_CUR_FIRST = 1'b1;

    typedef struct packed {
        logic       load_cur;
        logic       load_first;
        logic       load_prev;
        logic       pair_sel;
        logic       mul_en;
        logic [2:0] mul_idx;
        logic       acc_en;
        logic [2:0] acc_idx;
        logic       div_start;
        logic       div_sel;
        logic       out_load;
        logic       out_closing;
    } cli_cmd_t;

    typedef struct packed {
        logic singular;
        logic div_busy;
        logic div_done;
    } cli_status_t;

endpackage

// ===== src/cyclic_line_intersection_unit.sv =====
// Cyclic line intersection unit: top level joining controller and datapath.
// Depends on cli_pkg, cli_ctrl, cli_dpath and cli_div.
//
// Lines of a closed polygon (normal x, normal y, offset, signed fixed point)
// arrive one per transfer, tlast marking the final line. Every line after the
// first yields the intersection with the previous line; the final line also
// yields the closing intersection with the first line, sent with tlast set.
// A zero determinant gives a zero point with the singular flag; a clipped
// coordinate sets the saturated flag. One line is taken at a time. An
// intersection takes six products on the shared multiplier and two divisions
// on the single bit-serial divider; a singular pair skips the divisions. The
// final line of a run takes two intersections. The input is taken again while
// the last result still waits in the output register. The default format is Q16.16.
module cyclic_line_intersection_unit #(
    parameter int COORD_WIDTH = cli_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = cli_pkg::FRAC_BITS_DEF,
    localparam int IN_DATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // normal_x, normal_y, offset
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // point_x, point_y
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // singular, saturated
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int W = COORD_WIDTH;

    cli_pkg::cli_cmd_t    cmd;
    cli_pkg::cli_status_t status;
    logic signed [W-1:0]  point_x, point_y;
    logic                 singular, saturated, end_of_polygon;

    cli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_last  (s_axis_tlast),
        .s_ready (s_axis_tready),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .cmd     (cmd),
        .status  (status)
    );

    cli_dpath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .normal_x       (s_axis_tdata[W-1:0]),
        .normal_y       (s_axis_tdata[2*W-1:W]),
        .offset         (s_axis_tdata[3*W-1:2*W]),
        .point_x        (point_x),
        .point_y        (point_y),
        .singular       (singular),
        .saturated      (saturated),
        .end_of_polygon (end_of_polygon)
    );

    assign m_axis_tdata = OUT_DATA_W'({point_y, point_x});
    assign m_axis_tuser = {saturated, singular};
    assign m_axis_tlast = end_of_polygon;

    a_single_line_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a line is in progress");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
        else $error("singular result with nonzero point or saturation");

    a_div_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten before transfer");

endmodule

// ===== src/cli_div.sv =====
// Iterative signed divider, one quotient bit per cycle, with saturation.
// Computes (num << FRAC_BITS) / den truncated toward zero; depends on cli_pkg.
module cli_div #(
    parameter int COORD_WIDTH = cli_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = cli_pkg::FRAC_BITS_DEF,
    localparam int AW = 2 * COORD_WIDTH + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [AW-1:0]          num,
    input  logic signed [AW-1:0]          den,
    output logic                          busy,
    output logic                          done,
    output logic        [COORD_WIDTH-1:0] quot,
    output logic                          sat
);

    localparam int W  = COORD_WIDTH;
    localparam int NW = AW + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [NW-1:0] n_reg, n_next;
    logic [AW-1:0] rem_reg, rem_next;
    logic [AW-1:0] d_reg, d_next;
    logic [W:0]    q_reg, q_next;
    logic          ovf_reg, ovf_next;
    logic          neg_reg, neg_next;

    logic [AW-1:0] num_mag, den_mag;
    logic [AW:0]   rem_sh, diff;
    logic          ge;
    logic [W:0]    lim, mag;

    assign num_mag = num[AW-1] ? AW'(-num) : AW'(num);
    assign den_mag = den[AW-1] ? AW'(-den) : AW'(den);
    assign rem_sh  = {rem_reg, n_reg[NW-1]};
    assign diff    = rem_sh - {1'b0, d_reg};
    assign ge      = rem_sh >= {1'b0, d_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        n_next    = n_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        if (start) begin
            cnt_next = CW'(NW);
            n_next   = NW'(num_mag) << FRAC_BITS;
            rem_next = '0;
            d_next   = den_mag;
            q_next   = '0;
            ovf_next = 1'b0;
            neg_next = num[AW-1] ^ den[AW-1];
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
            n_next    = n_reg << 1;
            rem_next  = ge ? diff[AW-1:0] : rem_sh[AW-1:0];
            q_next    = {q_reg[W-1:0], ge};
            ovf_next  = ovf_reg | q_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        n_reg   <= n_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    assign lim  = neg_reg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    assign sat  = ovf_reg || (q_reg > lim);
    assign mag  = sat ? lim : q_reg;
    assign quot = neg_reg ? W'(-mag[W-1:0]) : mag[W-1:0];
    assign busy = (cnt_reg != '0);
    assign done = done_reg;

endmodule

// ===== src/cli_dpath.sv =====
// Datapath: line registers, shared multiplier, determinant accumulators,
// divider and result register. Depends on cli_pkg and cli_div.
module cli_dpath #(
    parameter int COORD_WIDTH = cli_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = cli_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cli_pkg::cli_cmd_t             cmd,
    output cli_pkg::cli_status_t          status,
    input  logic signed [COORD_WIDTH-1:0] normal_x,
    input  logic signed [COORD_WIDTH-1:0] normal_y,
    input  logic signed [COORD_WIDTH-1:0] offset,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output logic                          singular,
    output logic                          saturated,
    output logic                          end_of_polygon
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = 2 * W + 1;

    logic signed [W-1:0] cur_nx_reg, cur_ny_reg, cur_b_reg;
    logic signed [W-1:0] first_nx_reg, first_ny_reg, first_b_reg;
    logic signed [W-1:0] prev_nx_reg, prev_ny_reg, prev_b_reg;
    logic signed [W-1:0] l0_nx, l0_ny, l0_b, l1_nx, l1_ny, l1_b;
    logic signed [W-1:0] op_a, op_b;
    logic signed [2*W-1:0] prod_reg;
    logic signed [AW-1:0]  ext;
    logic signed [AW-1:0]  det_reg, dx_reg, dy_reg;
    logic signed [W-1:0]   qx_reg, qy_reg;
    logic                  satx_reg, saty_reg;
    logic signed [W-1:0]   px_reg, py_reg;
    logic                  sing_reg, sat_reg, eop_reg;
    logic                  det_zero;
    logic                  div_busy, div_done, div_sat;
    logic        [W-1:0]   div_quot;

    always_comb begin
        if (cmd.pair_sel == cli_pkg::PAIR_CUR_FIRST) begin
            l0_nx = cur_nx_reg;   l0_ny = cur_ny_reg;   l0_b = cur_b_reg;
            l1_nx = first_nx_reg; l1_ny = first_ny_reg; l1_b = first_b_reg;
        end else begin
            l0_nx = prev_nx_reg;  l0_ny = prev_ny_reg;  l0_b = prev_b_reg;
            l1_nx = cur_nx_reg;   l1_ny = cur_ny_reg;   l1_b = cur_b_reg;
        end
    end

    always_comb begin
        case (cmd.mul_idx)
            cli_pkg::PROD_DET0: begin op_a = l0_nx; op_b = l1_ny; end
            cli_pkg::PROD_DET1: begin op_a = l0_ny; op_b = l1_nx; end
            cli_pkg::PROD_DX0:  begin op_a = l0_b;  op_b = l1_ny; end
            cli_pkg::PROD_DX1:  begin op_a = l1_b;  op_b = l0_ny; end
            cli_pkg::PROD_DY0:  begin op_a = l0_nx; op_b = l1_b;  end
            cli_pkg::PROD_DY1:  begin op_a = l1_nx; op_b = l0_b;  end
            default:            begin op_a = '0;    op_b = '0;    end
        endcase
    end

    assign ext      = {prod_reg[2*W-1], prod_reg};
    assign det_zero = (det_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load_cur) begin
            cur_nx_reg <= normal_x;
            cur_ny_reg <= normal_y;
            cur_b_reg  <= offset;
        end
        if (cmd.load_first) begin
            first_nx_reg <= normal_x;
            first_ny_reg <= normal_y;
            first_b_reg  <= offset;
        end
        if (cmd.load_prev) begin
            prev_nx_reg <= cur_nx_reg;
            prev_ny_reg <= cur_ny_reg;
            prev_b_reg  <= cur_b_reg;
        end
        if (cmd.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.acc_en) begin
            case (cmd.acc_idx)
                cli_pkg::PROD_DET0: det_reg <= ext;
                cli_pkg::PROD_DET1: det_reg <= det_reg - ext;
                cli_pkg::PROD_DX0:  dx_reg  <= ext;
                cli_pkg::PROD_DX1:  dx_reg  <= dx_reg - ext;
                cli_pkg::PROD_DY0:  dy_reg  <= ext;
                cli_pkg::PROD_DY1:  dy_reg  <= dy_reg - ext;
                default: ;
            endcase
        end
        if (div_done) begin
            if (cmd.div_sel == cli_pkg::DIV_SEL_Y) begin
                qy_reg   <= div_quot;
                saty_reg <= div_sat;
            end else begin
                qx_reg   <= div_quot;
                satx_reg <= div_sat;
            end
        end
        if (cmd.out_load) begin
            px_reg   <= det_zero ? '0 : qx_reg;
            py_reg   <= det_zero ? '0 : qy_reg;
            sing_reg <= det_zero;
            sat_reg  <= !det_zero && (satx_reg || saty_reg);
            eop_reg  <= cmd.out_closing;
        end
    end

    cli_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     ((cmd.div_sel == cli_pkg::DIV_SEL_Y) ? dy_reg : dx_reg),
        .den     (det_reg),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot),
        .sat     (div_sat)
    );

    assign status.singular = det_zero;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

    assign point_x        = px_reg;
    assign point_y        = py_reg;
    assign singular       = sing_reg;
    assign saturated      = sat_reg;
    assign end_of_polygon = eop_reg;

endmodule

// ===== src/cli_ctrl.sv =====
// Controller: sequences products, divisions and result transfers per line
// and keeps the run state. Depends on cli_pkg.
module cli_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_last,
    output logic                 s_ready,
    input  logic                 m_ready,
    output logic                 m_valid,
    output cli_pkg::cli_cmd_t    cmd,
    input  cli_pkg::cli_status_t status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIVX   = 3'd2;
    localparam logic [2:0] ST_DIVX_W = 3'd3;
    localparam logic [2:0] ST_DIVY   = 3'd4;
    localparam logic [2:0] ST_DIVY_W = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       last_reg, last_next;
    logic       closing_reg, closing_next;
    logic       have_prev_reg, have_prev_next;
    logic       out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        closing_next   = closing_reg;
        have_prev_next = have_prev_reg;
        cmd             = '0;
        cmd.pair_sel    = closing_reg ? cli_pkg::PAIR_CUR_FIRST : cli_pkg::PAIR_PREV_CUR;
        cmd.out_closing = closing_reg;
        cmd.div_sel     = cli_pkg::DIV_SEL_X;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_cur   = 1'b1;
                    cmd.load_first = !have_prev_reg;
                    last_next      = s_last;
                    step_next      = '0;
                    if (have_prev_reg) begin
                        closing_next = 1'b0;
                        state_next   = ST_MUL;
                    end else if (s_last) begin
                        closing_next = 1'b1;
                        state_next   = ST_MUL;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_en  = (step_reg < cli_pkg::PROD_COUNT);
                cmd.mul_idx = step_reg;
                cmd.acc_en  = (step_reg != '0);
                cmd.acc_idx = step_reg - 3'd1;
                step_next   = step_reg + 3'd1;
                if (step_reg == cli_pkg::PROD_COUNT) begin
                    state_next = status.singular ? ST_OUT : ST_DIVX;
                end
            end
            ST_DIVX: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVX_W;
            end
            ST_DIVX_W: begin
                if (status.div_done) begin
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY: begin
                cmd.div_sel   = cli_pkg::DIV_SEL_Y;
                cmd.div_start = 1'b1;
                state_next    = ST_DIVY_W;
            end
            ST_DIVY_W: begin
                cmd.div_sel = cli_pkg::DIV_SEL_Y;
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    if (!closing_reg && last_reg) begin
                        closing_next = 1'b1;
                        step_next    = '0;
                        state_next   = ST_MUL;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                cmd.load_prev  = 1'b1;
                have_prev_next = !last_reg;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            closing_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            closing_reg   <= closing_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
